@@ design/elevator_trapezoid_motion_controller_macros.svh @@
// Assertion helpers for the elevator motion controller.
`ifndef ELEVATOR_TRAPEZOID_MOTION_CONTROLLER_MACROS_SVH
`define ELEVATOR_TRAPEZOID_MOTION_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define ETMC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("etmc assertion failed");
// Check that a condition holds in the cycle after a trigger.
`define ETMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("etmc assertion failed");
`else
`define ETMC_ASSERT(label, prop)
`define ETMC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/etmc_pkg.sv @@
package etmc_pkg;

    localparam int MAX_FLOORS = 16;
    localparam int TBL_AW     = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;

    localparam logic [1:0] CFG_MAX_SPEED   = 2'd0;
    localparam logic [1:0] CFG_ACCEL       = 2'd1;
    localparam logic [1:0] CFG_NUM_FLOORS  = 2'd2;
    localparam logic [1:0] CFG_START_FLOOR = 2'd3;

    localparam int CUE_START  = 0;
    localparam int CUE_ARRIVE = 1;
    localparam int CUE_BLOCK  = 2;
    localparam int CUE_WARN   = 3;

    localparam logic [15:0] SETTLE_FRAMES = 16'd60;
    localparam logic [16:0] WARN_FRAMES   = 17'd30;
    localparam logic [15:0] FRAME_MAX     = 16'hFFFF;
    localparam logic [30:0] LIMIT_MAX     = 31'h7FFF_FFFF;
    localparam logic [5:0]  MUL_STEPS     = 6'd30;
    localparam logic [5:0]  DIV_STEPS     = 6'd61;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_QUERY = 3'd1,
        CMD_UP    = 3'd2,
        CMD_DOWN  = 3'd3,
        CMD_WRITE = 3'd4,
        CMD_PARK  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_REST = 2'd0,
        MODE_MOVE = 2'd1,
        MODE_STOP = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_PARK_RD,
        ST_PARK_WB,
        ST_MV_RD,
        ST_MV_REM,
        ST_MV_RAMP,
        ST_PR_A,
        ST_PR_B,
        ST_TK_A,
        ST_TK_B,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [2:0]         command;
        logic [3:0]         floor_index;
        logic signed [31:0] floor_height;
        logic [3:0]         elapsed_frames;
    } req_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         current_floor;
        logic signed [31:0] height;
        logic               can_go_up;
        logic               can_go_down;
        logic [3:0]         cue_mask;
    } rsp_t;

endpackage

@@ design/etmc_ifs.sv @@
interface etmc_req_if;
    logic            valid;
    logic            ready;
    etmc_pkg::req_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface etmc_rsp_if;
    logic            valid;
    logic            ready;
    etmc_pkg::rsp_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface etmc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [30:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/etmc_ram.sv @@
module etmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/elevator_trapezoid_motion_controller.sv @@
// Elevator car controller with a trapezoidal speed profile in Q16.16. One request is
// taken at a time and answered with exactly one response; the next request is taken as
// soon as the sequencer is back in idle, even while the response still waits in its
// output register. A tick of a moving car passes the step unit; other ticks, queries, table
// writes and blocked moves go straight to the response. An accepted move predicts the
// frame count N (up to 65535): the shared speed/position step unit runs the whole travel
// once, one frame at a time. A park derives the ramp limit from a bit-serial multiply
// (31 steps) and restoring divide (62 steps); with a zero accel the divide is skipped.
`include "elevator_trapezoid_motion_controller_macros.svh"

module elevator_trapezoid_motion_controller (
    input  logic       clk,
    input  logic       rst_n,
    etmc_req_if.sink   req,
    etmc_rsp_if.source rsp,
    etmc_cfg_if.sink   cfg
);

    function automatic logic signed [31:0] sat_sum(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic sub);
        logic [32:0] s;
        s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
        if (s[32] != s[31])
        begin
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return signed'(s[31:0]);
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic signed [31:0] n;
        n = -v;
        return v[31] ? unsigned'(n) : unsigned'(v);
    endfunction

    function automatic logic [15:0] frame_add(input logic [15:0] base, input logic [3:0] el);
        logic [16:0] s;
        s = {1'b0, base} + {13'd0, el};
        return s[16] ? etmc_pkg::FRAME_MAX : s[15:0];
    endfunction

    logic [30:0] max_speed_reg;
    logic [30:0] accel_reg;
    logic [4:0]  num_floors_reg;
    logic [3:0]  start_floor_reg;

    etmc_pkg::state_t state_reg, state_next;
    etmc_pkg::mode_t  mode_reg, mode_next;
    logic [3:0]         last_floor_reg, last_floor_next;
    logic [3:0]         goal_floor_reg, goal_floor_next;
    logic signed [31:0] car_height_reg, car_height_next;
    logic signed [31:0] car_speed_reg, car_speed_next;
    logic signed [31:0] travelled_reg, travelled_next;
    logic signed [31:0] remaining_reg, remaining_next;
    logic [31:0]        ramp_dist_reg, ramp_dist_next;
    logic [30:0]        ramp_limit_reg, ramp_limit_next;
    logic signed [31:0] signed_accel_reg, signed_accel_next;
    logic signed [31:0] goal_height_reg, goal_height_next;
    logic [15:0]        frame_count_reg, frame_count_next;
    logic [15:0]        pred_frames_reg, pred_frames_next;
    logic signed [31:0] ns_reg, ns_next;
    logic signed [31:0] rem_start_reg, rem_start_next;
    logic [15:0]        iter_reg, iter_next;
    logic [31:0]        acc_reg, acc_next;
    logic [61:0]        sh_reg, sh_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [3:0]         el_reg, el_next;
    logic               up_reg, up_next;
    logic               down_reg, down_next;
    logic [3:0]         cue_reg, cue_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               rsp_valid_reg, rsp_valid_next;
    etmc_pkg::rsp_t     rsp_data_reg, rsp_data_next;

    // Table port
    logic                        tbl_we;
    logic [etmc_pkg::TBL_AW-1:0] tbl_raddr;
    logic [31:0]                 tbl_rdata;
    logic signed [31:0]          tbl_val;
    logic [3:0]                  rd_floor;

    logic req_fire;
    etmc_pkg::cmd_t cmd;

    // Shared step unit
    logic [31:0]        trav_mag, rem_mag, dif_mag, ns_mag;
    logic signed [31:0] max_s, accel_s, ns_comb, trav_sum, rem_dif, hgt_sum;
    logic               stop_comb;

    // Multiply / divide unit
    logic [31:0] mul_sum;
    logic [31:0] div_rs;
    logic        div_ge;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == etmc_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;
    assign cmd       = etmc_pkg::cmd_t'(req.data.command);

    assign tbl_we    = req_fire && (cmd == etmc_pkg::CMD_WRITE)
                       && (32'(req.data.floor_index) < etmc_pkg::MAX_FLOORS);
    assign rd_floor  = (state_reg == etmc_pkg::ST_PARK_RD) ? start_floor_reg : goal_floor_reg;
    assign tbl_raddr = etmc_pkg::TBL_AW'(rd_floor);
    assign tbl_val   = rd_ok_reg ? signed'(tbl_rdata) : 32'sd0;

    etmc_ram #(
        .WIDTH (32),
        .DEPTH (etmc_pkg::MAX_FLOORS)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (etmc_pkg::TBL_AW'(req.data.floor_index)),
        .wdata (req.data.floor_height),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    always_comb
    begin
        max_s    = signed'({1'b0, max_speed_reg});
        accel_s  = signed'({1'b0, accel_reg});
        trav_mag = mag32(travelled_reg);
        rem_mag  = mag32(remaining_reg);
        if (ramp_dist_reg <= trav_mag)
        begin
            if (ramp_dist_reg <= rem_mag)
            begin
                ns_comb = (remaining_reg <= 0) ? -max_s : max_s;
            end
            else
            begin
                ns_comb = sat_sum(car_speed_reg, signed_accel_reg, 1'b1);
            end
        end
        else
        begin
            ns_comb = sat_sum(car_speed_reg, signed_accel_reg, 1'b0);
        end
        trav_sum  = sat_sum(travelled_reg, ns_reg, 1'b0);
        rem_dif   = sat_sum(remaining_reg, ns_reg, 1'b1);
        hgt_sum   = sat_sum(car_height_reg, ns_reg, 1'b0);
        dif_mag   = mag32(rem_dif);
        ns_mag    = mag32(ns_reg);
        stop_comb = (car_speed_reg < 0 && ns_reg >= 0) || (car_speed_reg > 0 && ns_reg <= 0)
                    || (dif_mag < ns_mag);

        mul_sum = {1'b0, acc_reg[30:0]} + (sh_reg[0] ? {1'b0, max_speed_reg} : 32'd0);
        div_rs  = {acc_reg[30:0], sh_reg[61]};
        div_ge  = (div_rs >= {1'b0, accel_reg});
    end

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        last_floor_next   = last_floor_reg;
        goal_floor_next   = goal_floor_reg;
        car_height_next   = car_height_reg;
        car_speed_next    = car_speed_reg;
        travelled_next    = travelled_reg;
        remaining_next    = remaining_reg;
        ramp_dist_next    = ramp_dist_reg;
        ramp_limit_next   = ramp_limit_reg;
        signed_accel_next = signed_accel_reg;
        goal_height_next  = goal_height_reg;
        frame_count_next  = frame_count_reg;
        pred_frames_next  = pred_frames_reg;
        ns_next           = ns_reg;
        rem_start_next    = rem_start_reg;
        iter_next         = iter_reg;
        acc_next          = acc_reg;
        sh_next           = sh_reg;
        cnt_next          = cnt_reg;
        el_next           = el_reg;
        up_next           = up_reg;
        down_next         = down_reg;
        cue_next          = cue_reg;
        rd_ok_next        = rd_ok_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        rsp_data_next     = rsp_data_reg;

        case (state_reg)
            etmc_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    up_next    = 1'b0;
                    down_next  = 1'b0;
                    cue_next   = 4'd0;
                    el_next    = req.data.elapsed_frames;
                    state_next = etmc_pkg::ST_FIN;
                    case (cmd)
                        etmc_pkg::CMD_TICK:
                        begin
                            if (mode_reg == etmc_pkg::MODE_MOVE)
                            begin
                                state_next = etmc_pkg::ST_TK_A;
                            end
                            else
                            begin
                                if (mode_reg == etmc_pkg::MODE_STOP
                                    && frame_count_reg > etmc_pkg::SETTLE_FRAMES)
                                begin
                                    mode_next = etmc_pkg::MODE_REST;
                                end
                                frame_count_next = frame_add(frame_count_reg,
                                                             req.data.elapsed_frames);
                            end
                        end
                        etmc_pkg::CMD_QUERY:
                        begin
                            if (mode_reg == etmc_pkg::MODE_REST)
                            begin
                                up_next   = ({1'b0, last_floor_reg} + 5'd1) < num_floors_reg;
                                down_next = (last_floor_reg != 4'd0);
                            end
                        end
                        etmc_pkg::CMD_UP:
                        begin
                            if (mode_reg == etmc_pkg::MODE_REST)
                            begin
                                if (last_floor_reg != 4'd15
                                    && ({1'b0, last_floor_reg} + 5'd1) < num_floors_reg)
                                begin
                                    goal_floor_next          = last_floor_reg + 4'd1;
                                    cue_next[etmc_pkg::CUE_START] = 1'b1;
                                    state_next               = etmc_pkg::ST_MV_RD;
                                end
                                else
                                begin
                                    cue_next[etmc_pkg::CUE_BLOCK] = 1'b1;
                                end
                            end
                        end
                        etmc_pkg::CMD_DOWN:
                        begin
                            if (mode_reg == etmc_pkg::MODE_REST)
                            begin
                                if (last_floor_reg != 4'd0
                                    && ({1'b0, last_floor_reg} - 5'd1) < num_floors_reg)
                                begin
                                    goal_floor_next          = last_floor_reg - 4'd1;
                                    cue_next[etmc_pkg::CUE_START] = 1'b1;
                                    state_next               = etmc_pkg::ST_MV_RD;
                                end
                                else
                                begin
                                    cue_next[etmc_pkg::CUE_BLOCK] = 1'b1;
                                end
                            end
                        end
                        etmc_pkg::CMD_PARK:
                        begin
                            acc_next   = 32'd0;
                            sh_next    = {31'd0, max_speed_reg};
                            cnt_next   = etmc_pkg::MUL_STEPS;
                            state_next = etmc_pkg::ST_MUL;
                        end
                        default:
                        begin
                            state_next = etmc_pkg::ST_FIN;
                        end
                    endcase
                end
            end
            etmc_pkg::ST_MUL:
            begin
                acc_next = {1'b0, mul_sum[31:1]};
                sh_next  = {31'd0, mul_sum[0], sh_reg[30:1]};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    acc_next = 32'd0;
                    sh_next  = {mul_sum[31:1], mul_sum[0], sh_reg[30:1]};
                    cnt_next = etmc_pkg::DIV_STEPS;
                    if (accel_reg == 31'd0)
                    begin
                        ramp_limit_next = etmc_pkg::LIMIT_MAX;
                        state_next      = etmc_pkg::ST_PARK_RD;
                    end
                    else
                    begin
                        state_next = etmc_pkg::ST_DIV;
                    end
                end
            end
            etmc_pkg::ST_DIV:
            begin
                acc_next = div_ge ? (div_rs - {1'b0, accel_reg}) : div_rs;
                sh_next  = {sh_reg[60:0], div_ge};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    // Quotient halved, clamped to the positive range
                    ramp_limit_next = (sh_next[61:32] != 30'd0) ? etmc_pkg::LIMIT_MAX
                                                                 : sh_next[31:1];
                    state_next = etmc_pkg::ST_PARK_RD;
                end
            end
            etmc_pkg::ST_PARK_RD:
            begin
                rd_ok_next = (32'(start_floor_reg) < etmc_pkg::MAX_FLOORS);
                state_next = etmc_pkg::ST_PARK_WB;
            end
            etmc_pkg::ST_PARK_WB:
            begin
                last_floor_next  = start_floor_reg;
                goal_floor_next  = start_floor_reg;
                car_height_next  = tbl_val;
                mode_next        = etmc_pkg::MODE_REST;
                car_speed_next   = 32'sd0;
                frame_count_next = 16'd0;
                state_next       = etmc_pkg::ST_FIN;
            end
            etmc_pkg::ST_MV_RD:
            begin
                rd_ok_next = (32'(goal_floor_reg) < etmc_pkg::MAX_FLOORS);
                state_next = etmc_pkg::ST_MV_REM;
            end
            etmc_pkg::ST_MV_REM:
            begin
                goal_height_next = tbl_val;
                remaining_next   = sat_sum(tbl_val, car_height_reg, 1'b1);
                travelled_next   = 32'sd0;
                car_speed_next   = 32'sd0;
                frame_count_next = 16'd0;
                mode_next        = etmc_pkg::MODE_MOVE;
                state_next       = etmc_pkg::ST_MV_RAMP;
            end
            etmc_pkg::ST_MV_RAMP:
            begin
                // Short trips ramp over half the distance
                ramp_dist_next    = (rem_mag <= {ramp_limit_reg, 1'b0}) ? {1'b0, rem_mag[31:1]}
                                                                        : {1'b0, ramp_limit_reg};
                signed_accel_next = remaining_reg[31] ? -accel_s : accel_s;
                rem_start_next    = remaining_reg;
                iter_next         = 16'd0;
                state_next        = etmc_pkg::ST_PR_A;
            end
            etmc_pkg::ST_PR_A:
            begin
                ns_next    = ns_comb;
                state_next = etmc_pkg::ST_PR_B;
            end
            etmc_pkg::ST_PR_B:
            begin
                if (stop_comb || iter_reg == etmc_pkg::FRAME_MAX)
                begin
                    pred_frames_next = iter_reg;
                    car_speed_next   = 32'sd0;
                    travelled_next   = 32'sd0;
                    remaining_next   = rem_start_reg;
                    state_next       = etmc_pkg::ST_FIN;
                end
                else
                begin
                    iter_next      = iter_reg + 16'd1;
                    car_speed_next = ns_reg;
                    travelled_next = trav_sum;
                    remaining_next = rem_dif;
                    state_next     = etmc_pkg::ST_PR_A;
                end
            end
            etmc_pkg::ST_TK_A:
            begin
                ns_next    = ns_comb;
                state_next = etmc_pkg::ST_TK_B;
            end
            etmc_pkg::ST_TK_B:
            begin
                car_speed_next = ns_reg;
                travelled_next = trav_sum;
                remaining_next = rem_dif;
                if ({1'b0, pred_frames_reg} == ({1'b0, frame_count_reg} + etmc_pkg::WARN_FRAMES))
                begin
                    cue_next[etmc_pkg::CUE_WARN] = 1'b1;
                end
                if (stop_comb)
                begin
                    car_height_next  = goal_height_reg;
                    mode_next        = etmc_pkg::MODE_STOP;
                    last_floor_next  = goal_floor_reg;
                    cue_next[etmc_pkg::CUE_ARRIVE] = 1'b1;
                    frame_count_next = frame_add(16'd0, el_reg);
                end
                else
                begin
                    car_height_next  = hgt_sum;
                    frame_count_next = frame_add(frame_count_reg, el_reg);
                end
                state_next = etmc_pkg::ST_FIN;
            end
            etmc_pkg::ST_FIN:
            begin
                // Hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.mode          = mode_reg;
                    rsp_data_next.current_floor = last_floor_reg;
                    rsp_data_next.height        = car_height_reg;
                    rsp_data_next.can_go_up     = up_reg;
                    rsp_data_next.can_go_down   = down_reg;
                    rsp_data_next.cue_mask      = cue_reg;
                    state_next                  = etmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = etmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg    <= 31'd65536;
            accel_reg        <= 31'd4096;
            num_floors_reg   <= 5'd2;
            start_floor_reg  <= 4'd0;
            state_reg        <= etmc_pkg::ST_IDLE;
            mode_reg         <= etmc_pkg::MODE_REST;
            last_floor_reg   <= 4'd0;
            goal_floor_reg   <= 4'd0;
            car_height_reg   <= 32'sd0;
            car_speed_reg    <= 32'sd0;
            travelled_reg    <= 32'sd0;
            remaining_reg    <= 32'sd0;
            ramp_dist_reg    <= 32'd0;
            ramp_limit_reg   <= 31'd0;
            signed_accel_reg <= 32'sd0;
            goal_height_reg  <= 32'sd0;
            frame_count_reg  <= 16'd0;
            pred_frames_reg  <= 16'd0;
            ns_reg           <= 32'sd0;
            rem_start_reg    <= 32'sd0;
            iter_reg         <= 16'd0;
            acc_reg          <= 32'd0;
            sh_reg           <= 62'd0;
            cnt_reg          <= 6'd0;
            el_reg           <= 4'd0;
            up_reg           <= 1'b0;
            down_reg         <= 1'b0;
            cue_reg          <= 4'd0;
            rd_ok_reg        <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            rsp_data_reg     <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    etmc_pkg::CFG_MAX_SPEED:   max_speed_reg   <= cfg.data;
                    etmc_pkg::CFG_ACCEL:       accel_reg       <= cfg.data;
                    etmc_pkg::CFG_NUM_FLOORS:  num_floors_reg  <= cfg.data[4:0];
                    etmc_pkg::CFG_START_FLOOR: start_floor_reg <= cfg.data[3:0];
                    default:                   start_floor_reg <= start_floor_reg;
                endcase
            end
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            last_floor_reg   <= last_floor_next;
            goal_floor_reg   <= goal_floor_next;
            car_height_reg   <= car_height_next;
            car_speed_reg    <= car_speed_next;
            travelled_reg    <= travelled_next;
            remaining_reg    <= remaining_next;
            ramp_dist_reg    <= ramp_dist_next;
            ramp_limit_reg   <= ramp_limit_next;
            signed_accel_reg <= signed_accel_next;
            goal_height_reg  <= goal_height_next;
            frame_count_reg  <= frame_count_next;
            pred_frames_reg  <= pred_frames_next;
            ns_reg           <= ns_next;
            rem_start_reg    <= rem_start_next;
            iter_reg         <= iter_next;
            acc_reg          <= acc_next;
            sh_reg           <= sh_next;
            cnt_reg          <= cnt_next;
            el_reg           <= el_next;
            up_reg           <= up_next;
            down_reg         <= down_next;
            cue_reg          <= cue_next;
            rd_ok_reg        <= rd_ok_next;
            rsp_valid_reg    <= rsp_valid_next;
            rsp_data_reg     <= rsp_data_next;
        end
    end

    `ETMC_ASSERT_NEXT(a_busy_after_request, req_fire, state_reg != etmc_pkg::ST_IDLE)
    `ETMC_ASSERT(a_rsp_from_fin, $rose(rsp_valid_reg) |-> ($past(state_reg) == etmc_pkg::ST_FIN))
    `ETMC_ASSERT(a_floor_set_at_rest, (last_floor_reg != $past(last_floor_reg)) |-> (mode_reg != etmc_pkg::MODE_MOVE))

endmodule

@@ sim/etmc_tb_ifs.sv @@
`timescale 1ns / 100ps

// Testbench-side copies are not needed: the design interfaces are reused.
// This file holds the scoreboard class shared by the top module.
package etmc_tb_pkg;

    class motion_scoreboard;
        etmc_pkg::rsp_t expected_q[$];
        int   error_count;
        int   checked_count;

        function new();
            error_count = 0;
            checked_count = 0;
        endfunction

        function void note_request(etmc_pkg::rsp_t r);
            expected_q.push_back(r);
        endfunction

        function void check_response(etmc_pkg::rsp_t got);
            etmc_pkg::rsp_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: response with none expected: %h", $time, got);
                error_count++;
                return;
            end
            want = expected_q.pop_front();
            checked_count++;
            if (got.mode !== want.mode)
            begin
                $display("%0t: mode exp %0d got %0d", $time, want.mode, got.mode);
                error_count++;
            end
            if (got.current_floor !== want.current_floor)
            begin
                $display("%0t: floor exp %0d got %0d", $time, want.current_floor,
                         got.current_floor);
                error_count++;
            end
            if (got.height !== want.height)
            begin
                $display("%0t: height exp %h got %h", $time, want.height, got.height);
                error_count++;
            end
            if (got.can_go_up !== want.can_go_up)
            begin
                $display("%0t: up exp %b got %b", $time, want.can_go_up, got.can_go_up);
                error_count++;
            end
            if (got.can_go_down !== want.can_go_down)
            begin
                $display("%0t: down exp %b got %b", $time, want.can_go_down,
                         got.can_go_down);
                error_count++;
            end
            if (got.cue_mask !== want.cue_mask)
            begin
                $display("%0t: cue exp %h got %h", $time, want.cue_mask, got.cue_mask);
                error_count++;
            end
        endfunction
    endclass
endpackage

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    logic clk;
    logic rst_n;

    etmc_req_if req ();
    etmc_rsp_if rsp ();
    etmc_cfg_if cfg ();

    elevator_trapezoid_motion_controller dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    localparam longint CYCLE_LIMIT = 64'd200_000_000;

    etmc_tb_pkg::motion_scoreboard board;

    // predictor state
    logic [30:0] p_max_speed, p_accel;
    logic [4:0]  p_num_floors;
    logic [3:0]  p_start_floor;
    etmc_pkg::mode_t p_mode;
    logic [3:0]  p_last, p_goal;
    int          p_height, p_speed, p_trav, p_rem;
    int          p_ramp, p_ramp_lim, p_sacc, p_goal_h;
    int unsigned p_frames, p_predicted;
    int          p_table[16];

    int  send_idle, recv_idle;
    int  arrivals;
    int  requests_sent;
    longint cycles;

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic longint mag64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int speed_step(int spd, int trav, int remv);
        if (mag64(p_ramp) <= mag64(trav))
        begin
            if (mag64(p_ramp) <= mag64(remv))
                return (remv <= 0) ? -int'(p_max_speed) : int'(p_max_speed);
            return sat32(longint'(spd) - p_sacc);
        end
        return sat32(longint'(spd) + p_sacc);
    endfunction

    function automatic bit stop_reached(int prev, int now, int remv);
        return (prev < 0 && now >= 0) || (prev > 0 && now <= 0) ||
               mag64(remv) < mag64(now);
    endfunction

    function automatic void plan_travel(logic [3:0] nf);
        longint span;
        int spd, trav, remv, ns;
        int unsigned n;
        p_goal = nf;
        p_goal_h = p_table[nf];
        p_trav = 0;
        p_rem = sat32(longint'(p_goal_h) - p_height);
        span = mag64(p_rem);
        p_ramp = (span <= 2 * longint'(p_ramp_lim)) ? int'(span / 2) : p_ramp_lim;
        p_sacc = (p_rem < 0) ? -int'(p_accel) : int'(p_accel);
        p_mode = etmc_pkg::MODE_MOVE;
        p_speed = 0;
        p_frames = 0;
        spd = 0; trav = 0; remv = p_rem; n = 0;
        forever
        begin
            ns = speed_step(spd, trav, remv);
            trav = sat32(longint'(trav) + ns);
            remv = sat32(longint'(remv) - ns);
            if (stop_reached(spd, ns, remv) || n == 32'hFFFF)
                break;
            n++;
            spd = ns;
        end
        p_predicted = n;
    endfunction

    function automatic etmc_pkg::rsp_t car_response(etmc_pkg::req_t r);
        etmc_pkg::rsp_t o;
        logic [3:0] cue;
        logic up, down;
        int prev, left;
        logic [4:0] nf;
        longint unsigned sq, lim;
        cue = '0; up = 0; down = 0;
        case (r.command)
            etmc_pkg::CMD_TICK:
            begin
                if (p_mode == etmc_pkg::MODE_STOP)
                begin
                    if (p_frames > 60)
                        p_mode = etmc_pkg::MODE_REST;
                end
                else if (p_mode == etmc_pkg::MODE_MOVE)
                begin
                    prev = p_speed;
                    p_speed = speed_step(p_speed, p_trav, p_rem);
                    p_height = sat32(longint'(p_height) + p_speed);
                    left = int'(p_predicted) - int'(p_frames);
                    p_trav = sat32(longint'(p_trav) + p_speed);
                    p_rem = sat32(longint'(p_rem) - p_speed);
                    if (left == 30)
                        cue[etmc_pkg::CUE_WARN] = 1;
                    if (stop_reached(prev, p_speed, p_rem))
                    begin
                        p_height = p_goal_h;
                        p_mode = etmc_pkg::MODE_STOP;
                        p_frames = 0;
                        p_last = p_goal;
                        cue[etmc_pkg::CUE_ARRIVE] = 1;
                    end
                end
                p_frames += r.elapsed_frames;
                if (p_frames > 32'hFFFF)
                    p_frames = 32'hFFFF;
            end
            etmc_pkg::CMD_QUERY:
            begin
                if (p_mode == etmc_pkg::MODE_REST)
                begin
                    up = (5'(p_last) + 5'd1 < p_num_floors);
                    down = (p_last != 0);
                end
            end
            etmc_pkg::CMD_UP, etmc_pkg::CMD_DOWN:
            begin
                if (p_mode == etmc_pkg::MODE_REST)
                begin
                    bit ok;
                    if (r.command == etmc_pkg::CMD_UP)
                    begin
                        nf = 5'(p_last) + 5'd1;
                        ok = nf < p_num_floors && nf <= 15;
                    end
                    else
                    begin
                        ok = p_last != 0;
                        nf = 5'(p_last) - 5'd1;
                        if (ok)
                            ok = nf < p_num_floors;
                    end
                    if (ok)
                    begin
                        plan_travel(nf[3:0]);
                        cue[etmc_pkg::CUE_START] = 1;
                    end
                    else
                        cue[etmc_pkg::CUE_BLOCK] = 1;
                end
            end
            etmc_pkg::CMD_WRITE:
            begin
                p_table[r.floor_index] = r.floor_height;
            end
            etmc_pkg::CMD_PARK:
            begin
                sq = longint'(p_max_speed) * longint'(p_max_speed);
                lim = (p_accel != 0) ? (sq / p_accel) >> 1 : 64'h7FFF_FFFF;
                p_ramp_lim = (lim > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : int'(lim);
                p_last = p_start_floor;
                p_goal = p_start_floor;
                p_height = p_table[p_start_floor];
                p_mode = etmc_pkg::MODE_REST;
                p_speed = 0;
                p_frames = 0;
            end
            default: ;
        endcase
        o.mode = p_mode;
        o.current_floor = p_last;
        o.height = p_height;
        o.can_go_up = up;
        o.can_go_down = down;
        o.cue_mask = cue;
        return o;
    endfunction

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // response side: random stall, check on handshake
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                board.check_response(rsp.data);
                if (rsp.data.cue_mask[etmc_pkg::CUE_ARRIVE])
                    arrivals++;
            end
            rsp.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // valid stays high after the request so the next one can follow at once;
    // drop it while idling and in drain()
    task automatic send_request(etmc_pkg::req_t r);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data <= r;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        board.note_request(car_response(r));
        requests_sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            etmc_pkg::CFG_MAX_SPEED:   p_max_speed = val;
            etmc_pkg::CFG_ACCEL:       p_accel = val;
            etmc_pkg::CFG_NUM_FLOORS:  p_num_floors = val[4:0];
            default:                   p_start_floor = val[3:0];
        endcase
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        // let the handshakes settle
        repeat (200) @(posedge clk);
    endtask

    function automatic etmc_pkg::req_t make_req(etmc_pkg::cmd_t c, logic [3:0] idx, int h,
                                                logic [3:0] el);
        etmc_pkg::req_t r;
        r.command = c;
        r.floor_index = idx;
        r.floor_height = h;
        r.elapsed_frames = el;
        return r;
    endfunction

    // one trip: request a move then tick until it settles back to rest
    task automatic run_trip(etmc_pkg::cmd_t dir);
        int n;
        send_request(make_req(dir, 4'($urandom), $urandom, 4'($urandom)));
        n = 0;
        while (p_mode != etmc_pkg::MODE_REST && n < 400)
        begin
            send_request(make_req(etmc_pkg::CMD_TICK, 4'($urandom), $urandom,
                                  ($urandom_range(9) == 0) ? 4'd15 : 4'($urandom_range(3))));
            n++;
        end
    endtask

    function automatic int floor_height_pick(int i);
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom;
            default: return (i * 32'sh0000_2000) + $urandom_range(16'hFFF);
        endcase
    endfunction

    task automatic load_table();
        for (int i = 0; i < 16; i++)
            send_request(make_req(etmc_pkg::CMD_WRITE, 4'(i), floor_height_pick(i),
                                  4'($urandom)));
    endtask

    task automatic random_phase(int count);
        int k;
        int start;
        start = requests_sent;
        while (requests_sent - start < count)
        begin
            k = $urandom_range(99);
            if (k < 45)
                run_trip(($urandom_range(1) != 0) ? etmc_pkg::CMD_UP : etmc_pkg::CMD_DOWN);
            else if (k < 60)
                send_request(make_req(etmc_pkg::CMD_QUERY, 4'($urandom), $urandom,
                                      4'($urandom)));
            else if (k < 70)
                send_request(make_req(etmc_pkg::CMD_WRITE, 4'($urandom), floor_height_pick(3),
                                      4'($urandom)));
            else if (k < 78)
                send_request(make_req(etmc_pkg::CMD_PARK, 4'($urandom), $urandom,
                                      4'($urandom)));
            else if (k < 82)
                send_request(make_req(etmc_pkg::cmd_t'($urandom_range(6, 7)), 4'($urandom),
                                      $urandom, 4'($urandom)));
            else
                send_request(make_req(etmc_pkg::cmd_t'($urandom_range(0, 3)), 4'($urandom),
                                      $urandom, 4'($urandom)));
        end
    endtask

    task automatic set_profile(logic [30:0] spd, logic [30:0] acc, logic [4:0] nfl,
                               logic [3:0] sf);
        drain();
        write_reg(etmc_pkg::CFG_MAX_SPEED, spd);
        write_reg(etmc_pkg::CFG_ACCEL, acc);
        write_reg(etmc_pkg::CFG_NUM_FLOORS, nfl);
        write_reg(etmc_pkg::CFG_START_FLOOR, sf);
        cfg.valid <= 1'b0;
        send_request(make_req(etmc_pkg::CMD_PARK, 4'd0, 0, 4'd0));
    endtask

    initial
    begin
        board = new();
        cycles = 0;
        requests_sent = 0;
        arrivals = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        send_idle = 10;
        recv_idle = 80;
        p_max_speed = 31'd65536; p_accel = 31'd4096; p_num_floors = 5'd2;
        p_start_floor = 4'd0;
        p_mode = etmc_pkg::MODE_REST; p_last = 0; p_goal = 0;
        p_height = 0; p_speed = 0; p_trav = 0; p_rem = 0;
        p_ramp = 0; p_ramp_lim = 0; p_sacc = 0; p_goal_h = 0;
        p_frames = 0; p_predicted = 0;
        for (int i = 0; i < 16; i++)
            p_table[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill the table, query, blocked down from floor zero, short trip
        load_table();
        for (int i = 0; i < 16; i++)
            send_request(make_req(etmc_pkg::CMD_WRITE, 4'(i), i * 32'sh0001_0000, 4'hF));
        send_request(make_req(etmc_pkg::CMD_PARK, 4'd0, 0, 4'd0));
        send_request(make_req(etmc_pkg::CMD_QUERY, 4'd0, 0, 4'd0));
        send_request(make_req(etmc_pkg::CMD_DOWN, 4'd0, 0, 4'd0));
        send_request(make_req(etmc_pkg::cmd_t'(3'd7), 4'hF, 32'shFFFF_FFFF, 4'hF));
        run_trip(etmc_pkg::CMD_UP);
        send_request(make_req(etmc_pkg::CMD_UP, 4'd0, 0, 4'd0));
        send_request(make_req(etmc_pkg::CMD_QUERY, 4'd0, 0, 4'd0));
        run_trip(etmc_pkg::CMD_DOWN);

        // low speed, fast ramp, every floor in use
        set_profile(31'd32768, 31'd16384, 5'd16, 4'd0);
        send_idle = 10; recv_idle = 80;
        random_phase(600);

        // extremes: huge accel and speed, last floor as start
        set_profile(31'h7FFF_FFFF, 31'h7FFF_FFFF, 5'd16, 4'd15);
        load_table();
        send_idle = 80; recv_idle = 10;
        random_phase(200);

        // minimal floors and tiny accel
        set_profile(31'd1, 31'd1, 5'd1, 4'd0);
        random_phase(100);

        set_profile(31'd40000, 31'd3000, 5'd9, 4'd4);
        for (int i = 0; i < 16; i++)
            send_request(make_req(etmc_pkg::CMD_WRITE, 4'(i),
                                  i * 32'sh0002_0000 - 32'sh0008_0000, 4'd0));
        send_request(make_req(etmc_pkg::CMD_PARK, 4'd0, 0, 4'd0));
        send_idle = 0; recv_idle = 0;
        random_phase(900);

        drain();
        $display("covered %0d responses over several speed/accel/floor settings, %0d arrivals",
                 board.checked_count, arrivals);
        if (board.error_count == 0 && board.expected_q.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
